// ===== rtl/core/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
package bpc_pkg;

   // Press classifier phases
   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HELD     = 2'd2,
      PH_COOLDOWN = 2'd3
   } phase_type;

   // Register indexes on the CSR write channel
   localparam logic [1:0] REG_DEBOUNCE      = 2'd0;
   localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd1;
   localparam logic [1:0] REG_LONG_LIMIT    = 2'd2;

   // Register widths and reset values
   localparam int DEBOUNCE_WIDTH = 10;
   localparam int WINDOW_WIDTH   = 16;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET      = 10'd10;
   localparam logic [WINDOW_WIDTH-1:0]   DOUBLE_WINDOW_RESET = 16'd300;
   localparam logic [WINDOW_WIDTH-1:0]   LONG_LIMIT_RESET    = 16'd2000;

   // Configuration registers as one group
   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_ms;
      logic [WINDOW_WIDTH-1:0]   double_window_ms;
      logic [WINDOW_WIDTH-1:0]   long_limit_ms;
   } cfg_type;

   // Event flags produced for one tick
   typedef struct packed {
      logic long_hit;
      logic double_hit;
      logic single_hit;
   } result_type;

endpackage

// ===== rtl/core/bpc_step.sv =====
// Next-state and event logic for one millisecond tick.
module bpc_step #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                    btn_up,
   input  bpc_pkg::cfg_type        cfg,
   input  bpc_pkg::phase_type      phase,
   input  logic [TIME_WIDTH-1:0]   since_press,
   input  logic [TIME_WIDTH-1:0]   since_debounce,
   input  logic [TIME_WIDTH-1:0]   since_release,
   input  logic [TIME_WIDTH-1:0]   since_arm,
   input  logic [TIME_WIDTH-1:0]   hold_time,
   input  logic [TIME_WIDTH-1:0]   debounce_gap,
   input  logic                    single_armed,
   output bpc_pkg::phase_type      phase_in,
   output logic [TIME_WIDTH-1:0]   since_press_in,
   output logic [TIME_WIDTH-1:0]   since_debounce_in,
   output logic [TIME_WIDTH-1:0]   since_release_in,
   output logic [TIME_WIDTH-1:0]   since_arm_in,
   output logic [TIME_WIDTH-1:0]   hold_time_in,
   output logic [TIME_WIDTH-1:0]   debounce_gap_in,
   output logic                    single_armed_in,
   output bpc_pkg::result_type     result
);

   // Compare width: holds any counter, any register and the gap plus hold sum
   localparam int CW = ((TIME_WIDTH > bpc_pkg::WINDOW_WIDTH) ?
                        TIME_WIDTH : bpc_pkg::WINDOW_WIDTH) + 1;
   localparam logic [TIME_WIDTH-1:0] TICK_ONE = TIME_WIDTH'(1);

   logic [TIME_WIDTH-1:0] press_tick, deb_tick, rel_tick, arm_tick;
   logic [CW-1:0]         debounce_x, window_x, long_x;
   logic [CW-1:0]         press_x, sum_x, hold_x, arm_x, wait_x;

   // Saturating counter advance
   always_comb begin
      press_tick = (&since_press)    ? since_press    : since_press + TICK_ONE;
      deb_tick   = (&since_debounce) ? since_debounce : since_debounce + TICK_ONE;
      rel_tick   = (&since_release)  ? since_release  : since_release + TICK_ONE;
      arm_tick   = (&since_arm)      ? since_arm      : since_arm + TICK_ONE;
   end

   assign debounce_x = {{(CW-bpc_pkg::DEBOUNCE_WIDTH){1'b0}}, cfg.debounce_ms};
   assign window_x   = {{(CW-bpc_pkg::WINDOW_WIDTH){1'b0}}, cfg.double_window_ms};
   assign long_x     = {{(CW-bpc_pkg::WINDOW_WIDTH){1'b0}}, cfg.long_limit_ms};
   assign press_x    = {{(CW-TIME_WIDTH){1'b0}}, press_tick};
   assign sum_x      = {{(CW-TIME_WIDTH){1'b0}}, debounce_gap} +
                       {{(CW-TIME_WIDTH){1'b0}}, press_tick};

   // Phase machine, working on the advanced counters
   always_comb begin
      phase_in          = phase;
      since_press_in    = press_tick;
      since_debounce_in = deb_tick;
      since_release_in  = rel_tick;
      since_arm_in      = arm_tick;
      hold_time_in      = hold_time;
      debounce_gap_in   = debounce_gap;
      single_armed_in   = single_armed;
      result            = '0;
      case (phase)
         bpc_pkg::PH_IDLE: begin
            if (!btn_up) begin
               phase_in       = bpc_pkg::PH_DEBOUNCE;
               since_press_in = '0;
            end
         end
         bpc_pkg::PH_DEBOUNCE: begin
            if (btn_up) begin
               phase_in = bpc_pkg::PH_IDLE;
            end else if (press_x >= debounce_x) begin
               debounce_gap_in   = deb_tick;
               since_debounce_in = '0;
               phase_in          = bpc_pkg::PH_HELD;
            end
         end
         bpc_pkg::PH_HELD: begin
            if (btn_up) begin
               hold_time_in     = press_tick;
               since_release_in = '0;
               phase_in         = bpc_pkg::PH_COOLDOWN;
               if (sum_x < window_x) begin
                  single_armed_in   = 1'b0;
                  result.double_hit = 1'b1;
               end else begin
                  since_arm_in    = '0;
                  single_armed_in = 1'b1;
               end
            end else if (press_x >= long_x) begin
               hold_time_in    = press_tick;
               result.long_hit = 1'b1;
               phase_in        = bpc_pkg::PH_COOLDOWN;
            end
         end
         bpc_pkg::PH_COOLDOWN: begin
            if (btn_up && ({{(CW-TIME_WIDTH){1'b0}}, rel_tick} >= debounce_x)) begin
               phase_in = bpc_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = bpc_pkg::PH_IDLE;
         end
      endcase

      // Pending single press fires |window - hold| ticks after arming,
      // measured from the updated hold time and arm counter
      hold_x = {{(CW-TIME_WIDTH){1'b0}}, hold_time_in};
      arm_x  = {{(CW-TIME_WIDTH){1'b0}}, since_arm_in};
      wait_x = (window_x >= hold_x) ? (window_x - hold_x) : (hold_x - window_x);
      if (single_armed_in && (arm_x >= wait_x)) begin
         single_armed_in   = 1'b0;
         result.single_hit = 1'b1;
      end
   end

endmodule

// ===== rtl/core/button_press_classifier.sv =====
// Top level of the button press classifier: state, CSRs and result register.
//
// Each req transfer is one millisecond tick carrying the active-low button
// level; each one yields exactly one rsp transfer with the single, double and
// long press flags for that tick. A tick is accepted in every cycle and its
// result appears in the output register in the cycle after; the only limit on
// rate is the rsp side taking that register (a stalled result holds req_tready
// low). Registers are written on the csr channel, which is always ready, and
// are meant to be written while no tick is in flight.
module button_press_classifier #(
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] btn_level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] single flag, [1] double flag,
                                    // [2] long flag, [7:3] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   bpc_pkg::cfg_type     cfg_ff;
   bpc_pkg::phase_type   phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] since_press_ff, since_press_in;
   logic [TIME_WIDTH-1:0] since_debounce_ff, since_debounce_in;
   logic [TIME_WIDTH-1:0] since_release_ff, since_release_in;
   logic [TIME_WIDTH-1:0] since_arm_ff, since_arm_in;
   logic [TIME_WIDTH-1:0] hold_time_ff, hold_time_in;
   logic [TIME_WIDTH-1:0] debounce_gap_ff, debounce_gap_in;
   logic                  single_armed_ff, single_armed_in;
   bpc_pkg::result_type   result_in, rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  req_xfer;

   // Handshake: a new tick enters when the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.long_hit, rsp_data_ff.double_hit,
                        rsp_data_ff.single_hit};

   // CSR writes; index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= bpc_pkg::DEBOUNCE_RESET;
         cfg_ff.double_window_ms <= bpc_pkg::DOUBLE_WINDOW_RESET;
         cfg_ff.long_limit_ms    <= bpc_pkg::LONG_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bpc_pkg::REG_DEBOUNCE:
               cfg_ff.debounce_ms <= csr_data[bpc_pkg::DEBOUNCE_WIDTH-1:0];
            bpc_pkg::REG_DOUBLE_WINDOW: cfg_ff.double_window_ms <= csr_data;
            bpc_pkg::REG_LONG_LIMIT:    cfg_ff.long_limit_ms    <= csr_data;
            default: ;
         endcase
      end
   end

   bpc_step #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_step (
      .btn_up            (req_tdata[0]),
      .cfg               (cfg_ff),
      .phase             (phase_ff),
      .since_press       (since_press_ff),
      .since_debounce    (since_debounce_ff),
      .since_release     (since_release_ff),
      .since_arm         (since_arm_ff),
      .hold_time         (hold_time_ff),
      .debounce_gap      (debounce_gap_ff),
      .single_armed      (single_armed_ff),
      .phase_in          (phase_in),
      .since_press_in    (since_press_in),
      .since_debounce_in (since_debounce_in),
      .since_release_in  (since_release_in),
      .since_arm_in      (since_arm_in),
      .hold_time_in      (hold_time_in),
      .debounce_gap_in   (debounce_gap_in),
      .single_armed_in   (single_armed_in),
      .result            (result_in)
   );

   // Classifier state advances once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= bpc_pkg::PH_IDLE;
         since_press_ff    <= '0;
         since_debounce_ff <= '1;
         since_release_ff  <= '0;
         since_arm_ff      <= '0;
         hold_time_ff      <= '0;
         debounce_gap_ff   <= '0;
         single_armed_ff   <= 1'b0;
      end else if (req_xfer) begin
         phase_ff          <= phase_in;
         since_press_ff    <= since_press_in;
         since_debounce_ff <= since_debounce_in;
         since_release_ff  <= since_release_in;
         since_arm_ff      <= since_arm_in;
         hold_time_ff      <= hold_time_in;
         debounce_gap_ff   <= debounce_gap_in;
         single_armed_ff   <= single_armed_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= result_in;
      end
   end

   // A fresh result always matches the state it left behind
   a_long_to_cooldown: assert property (@(posedge clock) disable iff (reset)
      req_xfer && result_in.long_hit |=> phase_ff == bpc_pkg::PH_COOLDOWN)
      else $error("long press did not enter cooldown");

   a_double_clears_single: assert property (@(posedge clock) disable iff (reset)
      req_xfer && result_in.double_hit |=> !single_armed_ff)
      else $error("double press left a single press pending");

   a_single_disarms: assert property (@(posedge clock) disable iff (reset)
      req_xfer && result_in.single_hit |=> !single_armed_ff)
      else $error("single press fired but stayed armed");

   a_one_of_double_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.double_hit && rsp_data_ff.long_hit))
      else $error("double and long press on the same tick");

endmodule

// ===== tb/tb_button_press_classifier.sv =====
// Self-checking testbench for the button press classifier: tick stream in, press flags out.
module tb_button_press_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          TW           = 16;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_OFF_LEN = 200;
   // index past the end of the register list, must be ignored
   localparam logic [1:0]  REG_SPARE    = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [0] btn_level, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [0] single, [1] double, [2] long, [7:3] zero
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'd0;

   // gaps_on and hold_req_count are shared between the stimulus and the ready driver
   bit          gaps_on = 1'b1;
   int unsigned hold_req_count = 0;
   int unsigned mismatches = 0;
   int unsigned ticks_sent = 0;
   int unsigned cycle_count = 0;

   bpc_pkg::result_type  expected_flags[$];

   // Classifier state mirror
   bpc_pkg::cfg_type   model_cfg = {bpc_pkg::DEBOUNCE_RESET, bpc_pkg::DOUBLE_WINDOW_RESET,
                                    bpc_pkg::LONG_LIMIT_RESET};
   bpc_pkg::phase_type model_phase = bpc_pkg::PH_IDLE;
   logic [TW-1:0]  cnt_press = '0;
   logic [TW-1:0]  cnt_accept = '1;
   logic [TW-1:0]  cnt_release = '0;
   logic [TW-1:0]  cnt_arm = '0;
   logic [TW-1:0]  last_hold = '0;
   logic [TW-1:0]  accept_gap = '0;
   logic           single_pending = 1'b0;

   button_press_classifier #(.TIME_WIDTH(TW)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_button_press_classifier: FAIL");
         $finish;
      end
   end

   function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // Advance the mirror by one tick and return the flags it produces
   function automatic bpc_pkg::result_type classify_tick(input logic level);
      bpc_pkg::result_type flags;
      logic [TW:0]   span;
      logic [TW-1:0] arm_wait;
      flags = '0;
      cnt_press   = sat_inc(cnt_press);
      cnt_accept  = sat_inc(cnt_accept);
      cnt_release = sat_inc(cnt_release);
      cnt_arm     = sat_inc(cnt_arm);
      case (model_phase)
         bpc_pkg::PH_IDLE: begin
            if (!level) begin
               model_phase = bpc_pkg::PH_DEBOUNCE;
               cnt_press = '0;
            end
         end
         bpc_pkg::PH_DEBOUNCE: begin
            if (level) begin
               model_phase = bpc_pkg::PH_IDLE;
            end else if (cnt_press >= model_cfg.debounce_ms) begin
               accept_gap = cnt_accept;
               cnt_accept = '0;
               model_phase = bpc_pkg::PH_HELD;
            end
         end
         bpc_pkg::PH_HELD: begin
            if (level) begin
               last_hold = cnt_press;
               cnt_release = '0;
               // gap plus hold can exceed the counter width
               span = {1'b0, accept_gap} + {1'b0, last_hold};
               if (span < {1'b0, model_cfg.double_window_ms}) begin
                  single_pending = 1'b0;
                  flags.double_hit = 1'b1;
               end else begin
                  cnt_arm = '0;
                  single_pending = 1'b1;
               end
               model_phase = bpc_pkg::PH_COOLDOWN;
            end else if (cnt_press >= model_cfg.long_limit_ms) begin
               last_hold = cnt_press;
               flags.long_hit = 1'b1;
               model_phase = bpc_pkg::PH_COOLDOWN;
            end
         end
         default: begin
            if (level && cnt_release >= model_cfg.debounce_ms) model_phase = bpc_pkg::PH_IDLE;
         end
      endcase
      if (single_pending) begin
         arm_wait = (model_cfg.double_window_ms >= last_hold)
                    ? model_cfg.double_window_ms - last_hold
                    : last_hold - model_cfg.double_window_ms;
         if (cnt_arm >= arm_wait) begin
            single_pending = 1'b0;
            flags.single_hit = 1'b1;
         end
      end
      return flags;
   endfunction

   // Result ready: random short stalls, plus a long hold-off on request
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned hold_seen = 0;
   always @(negedge clock) begin
      if (hold_seen != hold_req_count) begin
         hold_seen <= hold_req_count;
         rsp_hold_left <= HOLD_OFF_LEN;
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void compare_flag(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         mismatches++;
      end
   endfunction

   // Check every result transfer against the oldest prediction
   always @(posedge clock) begin
      bpc_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_flags.size() == 0) begin
            $error("result transfer with no tick outstanding: tdata %02h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_flags.pop_front();
            compare_flag("single_hit", want.single_hit, rsp_tdata[0]);
            compare_flag("double_hit", want.double_hit, rsp_tdata[1]);
            compare_flag("long_hit", want.long_hit, rsp_tdata[2]);
         end
      end
   end

   // One tick transfer; starts and ends at a falling edge, leaves valid high
   task automatic send_tick(input logic level);
      int unsigned gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      do @(posedge clock); while (!req_tready);
      expected_flags.push_back(classify_tick(level));
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic press_release(input int unsigned down_ticks, input int unsigned up_ticks);
      repeat (down_ticks) send_tick(1'b0);
      repeat (up_ticks) send_tick(1'b1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_flags.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // One register transfer; leaves csr_valid high for a following write
   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         bpc_pkg::REG_DEBOUNCE:
            model_cfg.debounce_ms = value[bpc_pkg::DEBOUNCE_WIDTH-1:0];
         bpc_pkg::REG_DOUBLE_WINDOW: model_cfg.double_window_ms = value;
         bpc_pkg::REG_LONG_LIMIT:    model_cfg.long_limit_ms = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [15:0] debounce, input logic [15:0] window,
                               input logic [15:0] long_limit);
      wait_idle();
      write_reg(bpc_pkg::REG_DEBOUNCE, debounce);
      write_reg(bpc_pkg::REG_DOUBLE_WINDOW, window);
      write_reg(bpc_pkg::REG_LONG_LIMIT, long_limit);
      csr_valid <= 1'b0;
   endtask

   // Reset values: a bounce, then a single press with a saturated gap
   task automatic test_reset_defaults();
      press_release(3, 1);
      press_release(20, 300);
   endtask

   // A quick second press turns into a double and drops the pending single
   task automatic test_double_cancels_single();
      apply_config(16'd2, 16'd20, 16'd50);
      press_release(4, 3);
      press_release(4, 30);
   endtask

   // Hold equal to the window fires the single on the release tick
   task automatic test_immediate_single();
      apply_config(16'd2, 16'd6, 16'd50);
      press_release(6, 10);
   endtask

   // Zero debounce, zero window, zero long limit
   task automatic test_zero_settings();
      apply_config(16'd0, 16'd0, 16'd0);
      press_release(3, 3);
      press_release(1, 2);
      apply_config(16'd0, 16'd0, 16'd100);
      press_release(2, 6);
      press_release(4, 8);
   endtask

   // Cooldown after a long press counts from the release before it
   task automatic test_long_hold_exit();
      apply_config(16'd5, 16'd10, 16'd8);
      press_release(7, 7);
      press_release(15, 1);
      press_release(2, 4);
      press_release(20, 12);
   endtask

   // Writes to an index past the list change nothing
   task automatic test_spare_register();
      wait_idle();
      write_reg(REG_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
      press_release(6, 10);
   endtask

   // Debounce written with the upper data bits set, only the low bits count
   task automatic test_debounce_truncation();
      apply_config(16'hFC08, 16'd0, 16'hFFFF);
      press_release(12, 20);
   endtask

   // Long result hold-off while ticks keep coming, so the input stalls
   task automatic test_rsp_backpressure();
      apply_config(16'd1, 16'd8, 16'd12);
      gaps_on = 1'b0;
      hold_req_count++;
      repeat (8) press_release(5, 6);
      gaps_on = 1'b1;
   endtask

   // Random configs; mostly clean press/release pairs, some bouncing noise
   task automatic test_random_sequences();
      int unsigned window;
      int unsigned long_limit;
      int unsigned phase_end;
      for (int p = 0; p < 6; p++) begin
         window = $urandom_range(0, 40);
         long_limit = $urandom_range(0, 60);
         apply_config({6'($urandom), 10'($urandom_range(0, 6))}, 16'(window),
                      16'(long_limit));
         // odd phases run without gaps, the last one too
         gaps_on = (p % 2 == 0) && (p != 5);
         phase_end = ticks_sent + 115;
         while (ticks_sent < phase_end) begin
            if ($urandom_range(0, 4) != 0) begin
               press_release($urandom_range(1, long_limit + 8),
                             $urandom_range(0, window + 8));
            end else begin
               repeat ($urandom_range(1, 8)) send_tick(1'($urandom));
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_double_cancels_single();
      test_immediate_single();
      test_zero_settings();
      test_long_hold_exit();
      test_spare_register();
      test_debounce_truncation();
      test_rsp_backpressure();
      test_random_sequences();

      // drain, then allow the output register to settle
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_button_press_classifier: PASS");
      end else begin
         $display("tb_button_press_classifier: FAIL");
      end
      $finish;
   end

endmodule
